// ===== design/lmg_pkg.sv =====
package lmg_pkg;

  // default geometry
  localparam int DEF_LANDMARKS   = 21;
  localparam int DEF_SCALE_POINT = 9;

  // fixed arithmetic widths
  localparam int NUM_W   = 39;  // rounded dividend |d| << 22 plus half scale
  localparam int SC_W    = 25;  // scale root
  localparam int NQ_W    = 18;  // normalized Q4.14
  localparam int SQ_IN_W = 50;  // square root radicand
  localparam int SQ_RT_W = 25;  // square root result
  localparam int ACC_W   = 38;  // sum of three squares
  localparam int EN_W    = 22;  // energy accumulator before saturation

  localparam logic signed [NQ_W-1:0] NQ_MAX = 18'h1FFFF;
  localparam logic signed [NQ_W-1:0] NQ_MIN = 18'h20000;
  localparam logic [19:0]            E_MAX  = 20'hFFFFF;

  // gate events
  localparam logic [1:0] EV_CLOSED_IDLE  = 2'd0;
  localparam logic [1:0] EV_OPENED       = 2'd1;
  localparam logic [1:0] EV_STILL_OPEN   = 2'd2;
  localparam logic [1:0] EV_CYCLE_ENDED  = 2'd3;

  // register indexes
  localparam logic [2:0] REG_OPEN_LEVEL     = 3'd0;
  localparam logic [2:0] REG_CLOSE_LEVEL    = 3'd1;
  localparam logic [2:0] REG_OPEN_DWELL_MS  = 3'd2;
  localparam logic [2:0] REG_CLOSE_DWELL_MS = 3'd3;
  localparam logic [2:0] REG_FRAME_LIMIT    = 3'd4;

  typedef struct packed {
    logic               absent;
    logic [31:0]        timestamp_ms;
    logic [4:0]         point_index;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0] gate_event;
    logic [9:0] frame_count;
  } out_item_t;

  typedef struct packed {
    logic [19:0] open_level;
    logic [19:0] close_level;
    logic [15:0] open_dwell_ms;
    logic [15:0] close_dwell_ms;
    logic [9:0]  frame_limit;
  } cfg_t;

  // command from front to back
  typedef struct packed {
    logic        absent;
    logic [31:0] timestamp_ms;
  } cmd_t;

  // landmark store write
  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [47:0] data;
  } pt_wr_t;

  // back status toward front
  typedef struct packed {
    logic frame_busy;
    logic frame_done;
  } bk_status_t;

  function automatic logic signed [15:0] pt_comp(input logic [47:0] p, input logic [1:0] k);
    logic signed [15:0] r;
    case (k)
      2'd0:    r = p[47:32];
      2'd1:    r = p[31:16];
      default: r = p[15:0];
    endcase
    return r;
  endfunction

endpackage

// ===== design/lmg_div.sv =====
module lmg_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [lmg_pkg::NUM_W-1:0] num,
  input  logic [lmg_pkg::SC_W-1:0]  den,
  output logic                      done,
  output logic [lmg_pkg::NQ_W-1:0]  quo
);
  import lmg_pkg::*;

  logic [SC_W:0]   rem;
  logic [SC_W:0]   rem_sh;
  logic [NQ_W-1:0] lo;
  logic [4:0]      cnt;
  logic            busy;

  // one quotient bit per cycle, dividend known below den << NQ_W
  assign rem_sh = {rem[SC_W-1:0], lo[NQ_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= (SC_W+1)'(num[NUM_W-1:NQ_W]);
        lo   <= num[NQ_W-1:0];
        quo  <= '0;
        cnt  <= 5'(NQ_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (rem_sh >= {1'b0, den}) begin
          rem <= rem_sh - {1'b0, den};
          quo <= {quo[NQ_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[NQ_W-2:0], 1'b0};
        end
        lo  <= {lo[NQ_W-2:0], 1'b0};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/lmg_isqrt.sv =====
module lmg_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lmg_pkg::SQ_IN_W-1:0] x,
  output logic                        done,
  output logic [lmg_pkg::SQ_RT_W-1:0] root
);
  import lmg_pkg::*;

  localparam int RW = SQ_RT_W + 3;

  logic [SQ_IN_W-1:0] xs;
  logic [RW-1:0]      rem;
  logic [RW-1:0]      rem_sh;
  logic [RW-1:0]      trial;
  logic [4:0]         cnt;
  logic               busy;

  // two radicand bits per cycle
  assign rem_sh = {rem[RW-3:0], xs[SQ_IN_W-1:SQ_IN_W-2]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xs   <= x;
        rem  <= '0;
        root <= '0;
        cnt  <= 5'(SQ_RT_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[SQ_RT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[SQ_RT_W-2:0], 1'b0};
        end
        xs  <= {xs[SQ_IN_W-3:0], 2'b00};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/lmg_front.sv =====
module lmg_front #(
  parameter int LANDMARKS = lmg_pkg::DEF_LANDMARKS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lmg_pkg::in_item_t   in_data,
  output lmg_pkg::pt_wr_t     pt_wr,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output lmg_pkg::cmd_t       cmd,
  input  lmg_pkg::bk_status_t status
);
  import lmg_pkg::*;

  cmd_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] cnt;
  logic       frame_out;
  logic       accept;
  logic       in_range;
  logic       is_last;
  logic       push;
  logic       pop;

  // classify the incoming transaction
  assign accept   = in_valid && in_ready;
  assign in_range = {1'b0, in_data.point_index} < 6'(LANDMARKS);
  assign is_last  = in_data.point_index == 5'(LANDMARKS - 1);
  assign push     = accept && (in_data.absent || is_last);
  assign pop      = cmd_valid && cmd_ready;

  // landmarks wait while a frame is still being read by the back or the command queue is full
  assign in_ready = (cnt != 2'd2) && !frame_out;

  assign pt_wr.en   = accept && !in_data.absent && in_range;
  assign pt_wr.addr = in_data.point_index;
  assign pt_wr.data = {in_data.point_x, in_data.point_y, in_data.point_z};

  assign cmd_valid = cnt != 2'd0;
  assign cmd       = q[rptr];

  // two-entry command queue
  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr].absent       <= in_data.absent;
      q[wptr].timestamp_ms <= in_data.timestamp_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr      <= 1'b0;
      rptr      <= 1'b0;
      cnt       <= 2'd0;
      frame_out <= 1'b0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
      if (push && !in_data.absent) begin
        frame_out <= 1'b1;
      end else if (status.frame_done) begin
        frame_out <= 1'b0;
      end
    end
  end

endmodule

// ===== design/lmg_back.sv =====
module lmg_back #(
  parameter int LANDMARKS   = lmg_pkg::DEF_LANDMARKS,
  parameter int SCALE_POINT = lmg_pkg::DEF_SCALE_POINT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  lmg_pkg::cmd_t       cmd,
  input  lmg_pkg::pt_wr_t     pt_wr,
  input  lmg_pkg::cfg_t       cfg,
  output logic                out_valid,
  input  logic                out_ready,
  output lmg_pkg::out_item_t  out_data,
  output lmg_pkg::bk_status_t status
);
  import lmg_pkg::*;

  localparam int AW = $clog2(LANDMARKS);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_W0A   = 5'd1;
  localparam logic [4:0] ST_W0B   = 5'd2;
  localparam logic [4:0] ST_SPA   = 5'd3;
  localparam logic [4:0] ST_SPB   = 5'd4;
  localparam logic [4:0] ST_SPACC = 5'd5;
  localparam logic [4:0] ST_SCHK  = 5'd6;
  localparam logic [4:0] ST_SCW   = 5'd7;
  localparam logic [4:0] ST_PA    = 5'd8;
  localparam logic [4:0] ST_PB    = 5'd9;
  localparam logic [4:0] ST_DVS   = 5'd10;
  localparam logic [4:0] ST_DVW   = 5'd11;
  localparam logic [4:0] ST_MUL   = 5'd12;
  localparam logic [4:0] ST_MACC  = 5'd13;
  localparam logic [4:0] ST_QSS   = 5'd14;
  localparam logic [4:0] ST_QSW   = 5'd15;
  localparam logic [4:0] ST_GATE  = 5'd16;
  localparam logic [4:0] ST_OUT   = 5'd17;

  logic [4:0] state;

  // landmark and previous-frame stores
  logic [47:0]       pts_mem  [LANDMARKS];
  logic [3*NQ_W-1:0] prev_mem [LANDMARKS];
  logic [47:0]       pts_rd;
  logic [3*NQ_W-1:0] prev_rd;
  logic [AW-1:0]     rd_addr;
  logic              prev_we;

  logic [31:0]              now;
  logic signed [15:0]       w0   [3];
  logic [47:0]              p;
  logic [3*NQ_W-1:0]        prv;
  logic signed [NQ_W-1:0]   cur  [3];
  logic [1:0]               k;
  logic [AW-1:0]            idx;
  logic [ACC_W-1:0]         sacc;
  logic [ACC_W-2:0]         prod;
  logic [SC_W-1:0]          sc;
  logic [EN_W-1:0]          energy;
  logic                     cur_valid;
  logic signed [16:0]       d_cur;
  logic                     dsat;

  // gate state
  logic        pvalid;
  logic        gate_open;
  logic [31:0] hs;
  logic        hsv;
  logic [31:0] ls;
  logic        lsv;
  logic [9:0]  open_count;

  // arithmetic units
  logic                div_start;
  logic [NUM_W-1:0]    div_num;
  logic                div_done;
  logic [NQ_W-1:0]     div_quo;
  logic                sq_start;
  logic [SQ_IN_W-1:0]  sq_x;
  logic                sq_done;
  logic [SQ_RT_W-1:0]  sq_root;

  lmg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (sc),
    .done  (div_done),
    .quo   (div_quo)
  );

  lmg_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (pt_wr.en) pts_mem[pt_wr.addr[AW-1:0]] <= pt_wr.data;
    pts_rd <= pts_mem[rd_addr];
  end

  assign prev_we = (state == ST_QSW) && sq_done;

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[rd_addr] <= {cur[0], cur[1], cur[2]};
    prev_rd <= prev_mem[rd_addr];
  end

  // shared squarer operand
  logic signed [18:0] mul_a;
  logic signed [37:0] mul_p;

  always_comb begin
    if (state == ST_SPB) begin
      mul_a = 19'(pt_comp(pts_rd, k)) - 19'(w0[k]);
    end else begin
      mul_a = 19'(cur[k]) - 19'($signed(prv[(2 - k) * NQ_W +: NQ_W]));
    end
  end

  assign mul_p = mul_a * mul_a;

  // divider setup for the current coordinate
  logic signed [16:0] d_new;
  logic [16:0]        d_abs;
  logic [NUM_W-1:0]   num_new;
  logic               sat_new;

  assign d_new   = 17'(pt_comp(p, k)) - 17'(w0[k]);
  assign d_abs   = d_new[16] ? 17'(-d_new) : d_new;
  assign num_new = {1'b0, d_abs[15:0], 22'b0} + NUM_W'(sc[SC_W-1:1]);
  assign sat_new = {4'b0, num_new} >= {sc, 18'b0};

  // rounding result to saturated Q4.14
  logic signed [NQ_W-1:0] nq;

  always_comb begin
    if (dsat) begin
      nq = d_cur[16] ? NQ_MIN : NQ_MAX;
    end else if (!d_cur[16]) begin
      nq = (div_quo > 18'd131071) ? NQ_MAX : $signed(div_quo);
    end else begin
      nq = (div_quo > 18'd131072) ? NQ_MIN : $signed(~div_quo + 18'd1);
    end
  end

  // gate decision for a completed frame
  logic [19:0] e;
  logic [31:0] hs_use;
  logic [31:0] ls_use;
  logic [9:0]  cnt_n;
  logic        close;
  logic        g_open;
  logic [31:0] g_hs;
  logic        g_hsv;
  logic [31:0] g_ls;
  logic        g_lsv;
  logic [9:0]  g_cnt;
  out_item_t   g_out;

  always_comb begin
    e      = (cur_valid && pvalid) ?
             ((energy > EN_W'(E_MAX)) ? E_MAX : energy[19:0]) : 20'd0;
    hs_use = hsv ? hs : now;
    ls_use = lsv ? ls : now;
    cnt_n  = (open_count < cfg.frame_limit) ? open_count + 10'd1 : open_count;
    close  = 1'b0;
    g_open = gate_open;
    g_hs   = hs;
    g_hsv  = hsv;
    g_ls   = ls;
    g_lsv  = lsv;
    g_cnt  = open_count;
    g_out  = '{gate_event: EV_CLOSED_IDLE, frame_count: 10'd0};
    if (!gate_open) begin
      if (e > cfg.open_level) begin
        g_hs  = hs_use;
        g_hsv = 1'b1;
        if ((now - hs_use) >= {16'b0, cfg.open_dwell_ms}) begin
          g_open = 1'b1;
          g_hs   = '0;
          g_hsv  = 1'b0;
          g_ls   = '0;
          g_lsv  = 1'b0;
          g_cnt  = '0;
          g_out.gate_event = EV_OPENED;
        end
      end else begin
        g_hsv = 1'b0;
      end
    end else begin
      g_cnt = cnt_n;
      if (e < cfg.close_level) begin
        g_ls  = ls_use;
        g_lsv = 1'b1;
        if ((now - ls_use) >= {16'b0, cfg.close_dwell_ms}) close = 1'b1;
      end else begin
        g_lsv = 1'b0;
      end
      if (cnt_n >= cfg.frame_limit) close = 1'b1;
      if (close) begin
        g_open = 1'b0;
        g_hs   = '0;
        g_hsv  = 1'b0;
        g_ls   = '0;
        g_lsv  = 1'b0;
        g_cnt  = '0;
        g_out  = '{gate_event: EV_CYCLE_ENDED, frame_count: cnt_n};
      end else begin
        g_out  = '{gate_event: EV_STILL_OPEN, frame_count: cnt_n};
      end
    end
  end

  assign cmd_ready         = state == ST_IDLE;
  assign status.frame_done = state == ST_GATE;
  assign status.frame_busy = (state != ST_IDLE) && (state != ST_OUT) && (state != ST_GATE);

  // frame sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      div_start  <= 1'b0;
      sq_start   <= 1'b0;
      pvalid     <= 1'b0;
      gate_open  <= 1'b0;
      hs         <= '0;
      hsv        <= 1'b0;
      ls         <= '0;
      lsv        <= 1'b0;
      open_count <= '0;
    end else begin
      div_start <= 1'b0;
      sq_start  <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            now <= cmd.timestamp_ms;
            if (cmd.absent) begin
              out_data   <= gate_open ?
                            out_item_t'{gate_event: EV_CYCLE_ENDED, frame_count: open_count} :
                            out_item_t'{gate_event: EV_CLOSED_IDLE, frame_count: 10'd0};
              out_valid  <= 1'b1;
              pvalid     <= 1'b0;
              gate_open  <= 1'b0;
              hs         <= '0;
              hsv        <= 1'b0;
              ls         <= '0;
              lsv        <= 1'b0;
              open_count <= '0;
              state      <= ST_OUT;
            end else begin
              rd_addr <= '0;
              state   <= ST_W0A;
            end
          end
        end
        ST_W0A: state <= ST_W0B;
        ST_W0B: begin
          w0[0]   <= pt_comp(pts_rd, 2'd0);
          w0[1]   <= pt_comp(pts_rd, 2'd1);
          w0[2]   <= pt_comp(pts_rd, 2'd2);
          rd_addr <= AW'(SCALE_POINT);
          k       <= 2'd0;
          sacc    <= '0;
          state   <= ST_SPA;
        end
        ST_SPA: state <= ST_SPB;
        ST_SPB: begin
          prod  <= mul_p[ACC_W-2:0];
          state <= ST_SPACC;
        end
        ST_SPACC: begin
          sacc <= sacc + ACC_W'(prod);
          if (k == 2'd2) begin
            state <= ST_SCHK;
          end else begin
            k     <= k + 2'd1;
            state <= ST_SPB;
          end
        end
        ST_SCHK: begin
          energy <= '0;
          if (sacc == '0) begin
            cur_valid <= 1'b0;
            state     <= ST_GATE;
          end else begin
            cur_valid <= 1'b1;
            sq_x      <= {sacc[33:0], 16'b0};
            sq_start  <= 1'b1;
            state     <= ST_SCW;
          end
        end
        ST_SCW: begin
          if (sq_done) begin
            sc      <= sq_root;
            idx     <= '0;
            rd_addr <= '0;
            state   <= ST_PA;
          end
        end
        ST_PA: state <= ST_PB;
        ST_PB: begin
          p     <= pts_rd;
          prv   <= prev_rd;
          k     <= 2'd0;
          sacc  <= '0;
          state <= ST_DVS;
        end
        ST_DVS: begin
          d_cur     <= d_new;
          dsat      <= sat_new;
          div_num   <= num_new;
          div_start <= !sat_new;
          state     <= ST_DVW;
        end
        ST_DVW: begin
          if (dsat || div_done) begin
            cur[k] <= nq;
            if (k == 2'd2) begin
              k     <= 2'd0;
              state <= ST_MUL;
            end else begin
              k     <= k + 2'd1;
              state <= ST_DVS;
            end
          end
        end
        ST_MUL: begin
          prod  <= mul_p[ACC_W-2:0];
          state <= ST_MACC;
        end
        ST_MACC: begin
          sacc <= sacc + ACC_W'(prod);
          if (k == 2'd2) begin
            state <= ST_QSS;
          end else begin
            k     <= k + 2'd1;
            state <= ST_MUL;
          end
        end
        ST_QSS: begin
          sq_x     <= SQ_IN_W'(sacc);
          sq_start <= 1'b1;
          state    <= ST_QSW;
        end
        ST_QSW: begin
          if (sq_done) begin
            energy <= energy + EN_W'(sq_root[SQ_RT_W-1:4]);
            if (idx == AW'(LANDMARKS - 1)) begin
              state <= ST_GATE;
            end else begin
              idx     <= idx + 1'b1;
              rd_addr <= idx + 1'b1;
              state   <= ST_PA;
            end
          end
        end
        ST_GATE: begin
          pvalid     <= cur_valid;
          gate_open  <= g_open;
          hs         <= g_hs;
          hsv        <= g_hsv;
          ls         <= g_ls;
          lsv        <= g_lsv;
          open_count <= g_cnt;
          out_data   <= g_out;
          out_valid  <= 1'b1;
          state      <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/landmark_motion_gate_core.sv =====
// Hand-landmark motion gate. Landmarks enter one per transaction in index order;
// every landmark in range, the last of a frame too, is written to the store as it
// is taken. The last landmark, or an absent-hand transaction, also becomes a command
// for the back end, which produces exactly one result per command. The time a frame
// takes is set by the shared one-bit-a-cycle divider (three normalizations per
// landmark) and the shared two-bits-a-cycle square root unit. While a frame is being
// worked on, new landmarks wait because the back end still reads the landmark store;
// configuration writes are always taken and must only be issued while the block is
// idle.
module landmark_motion_gate_core #(
  parameter int LANDMARKS   = lmg_pkg::DEF_LANDMARKS,
  parameter int SCALE_POINT = lmg_pkg::DEF_SCALE_POINT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lmg_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lmg_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data
);
  import lmg_pkg::*;

  cfg_t       cfg;
  pt_wr_t     pt_wr;
  cmd_t       cmd;
  logic       cmd_valid;
  logic       cmd_ready;
  bk_status_t status;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_level     <= 20'd512;
      cfg.close_level    <= 20'd256;
      cfg.open_dwell_ms  <= 16'd100;
      cfg.close_dwell_ms <= 16'd200;
      cfg.frame_limit    <= 10'd60;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OPEN_LEVEL:     cfg.open_level     <= cfg_data;
        REG_CLOSE_LEVEL:    cfg.close_level    <= cfg_data;
        REG_OPEN_DWELL_MS:  cfg.open_dwell_ms  <= cfg_data[15:0];
        REG_CLOSE_DWELL_MS: cfg.close_dwell_ms <= cfg_data[15:0];
        REG_FRAME_LIMIT:    cfg.frame_limit    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  lmg_front #(
    .LANDMARKS (LANDMARKS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .pt_wr     (pt_wr),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .status    (status)
  );

  lmg_back #(
    .LANDMARKS   (LANDMARKS),
    .SCALE_POINT (SCALE_POINT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .pt_wr     (pt_wr),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .status    (status)
  );

  // landmark store is never written while the back end reads a frame
  a_no_write_in_frame: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !status.frame_busy)
    else $error("landmark accepted while a frame is being processed");

  // an opening carries no count
  a_opened_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.gate_event == EV_OPENED |-> out_data.frame_count == 10'd0)
    else $error("opened event with nonzero count");

  // a closed gate reports no count
  a_closed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.gate_event == EV_CLOSED_IDLE |-> out_data.frame_count == 10'd0)
    else $error("closed-gate event with nonzero count");

endmodule

// ===== tb/landmark_motion_gate_core_tb.sv =====
module landmark_motion_gate_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmg_pkg::*;

  localparam int LM = 21;
  localparam int SP = 9;
  localparam int LAST = LM - 1;
  localparam int SETTLE_CYCLES = 2500;
  localparam int PHASE_ITEMS = 125;
  localparam longint CYCLE_LIMIT = 20000000;

  // directed row kinds
  localparam int ROW_ABSENT = 0;
  localparam int ROW_POINT  = 1;
  localparam int ROW_FRAME  = 2;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [2:0]  cfg_index;
  logic [19:0] cfg_data;

  landmark_motion_gate_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // gate model state
  int signed   lm_store [LM][3];
  int signed   last_norm [LM][3];
  bit          last_norm_ok;
  bit          gate_is_open;
  bit [31:0]   high_t0, low_t0;
  bit          high_t0_ok, low_t0_ok;
  int unsigned open_frames;
  cfg_t        regs;

  out_item_t   pending_events [$];
  int          fail_count;
  longint      cycle_count;
  bit          calm;
  bit          typed_on;
  out_item_t   typed_event;

  function automatic longint unsigned int_root(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // rounded division to Q4.14 with saturation
  function automatic int signed norm_coord(longint signed d, longint unsigned sc);
    longint unsigned mag, q;
    mag = longint'(d < 0 ? -d : d) << 22;
    q = (mag + sc / 2) / sc;
    if (d < 0) return (q > 64'd131072) ? -131072 : -int'(q);
    return (q > 64'd131071) ? 131071 : int'(q);
  endfunction

  function automatic void clear_gate_model();
    gate_is_open = 1'b0;
    high_t0_ok = 1'b0;
    low_t0_ok = 1'b0;
    high_t0 = '0;
    low_t0 = '0;
    open_frames = 0;
  endfunction

  function automatic void gate_event_for(input in_item_t it, output bit has,
                                         output out_item_t r);
    longint signed   d;
    longint unsigned s, sc, q, acc;
    int signed       cur [LM][3];
    bit              cur_ok, open_before, close_now;
    bit [31:0]       en, now;
    int unsigned     c;
    has = 1'b1;
    r = '0;
    now = it.timestamp_ms;
    en = '0;
    // absent hand
    if (it.absent) begin
      open_before = gate_is_open;
      c = open_frames;
      last_norm_ok = 1'b0;
      clear_gate_model();
      r.gate_event = open_before ? EV_CYCLE_ENDED : EV_CLOSED_IDLE;
      r.frame_count = open_before ? c[9:0] : '0;
      return;
    end
    if (it.point_index >= LM) begin
      has = 1'b0;
      return;
    end
    lm_store[it.point_index][0] = it.point_x;
    lm_store[it.point_index][1] = it.point_y;
    lm_store[it.point_index][2] = it.point_z;
    if (it.point_index != LAST) begin
      has = 1'b0;
      return;
    end
    // normalize against the wrist
    s = 0;
    for (int k = 0; k < 3; k++) begin
      d = longint'(lm_store[SP][k]) - longint'(lm_store[0][k]);
      s += longint'(d * d);
    end
    cur_ok = (s != 0);
    sc = cur_ok ? int_root(s << 16) : 64'd1;
    if (sc == 0) sc = 1;
    for (int i = 0; i < LM; i++)
      for (int k = 0; k < 3; k++)
        cur[i][k] = cur_ok ?
          norm_coord(longint'(lm_store[i][k]) - longint'(lm_store[0][k]), sc) : 0;
    // motion energy
    if (cur_ok && last_norm_ok) begin
      acc = 0;
      for (int i = 0; i < LM; i++) begin
        q = 0;
        for (int k = 0; k < 3; k++) begin
          d = longint'(cur[i][k]) - longint'(last_norm[i][k]);
          q += longint'(d * d);
        end
        acc += int_root(q) >> 4;
      end
      en = (acc > 64'd1048575) ? 32'd1048575 : acc[31:0];
    end
    if (cur_ok) last_norm = cur;
    last_norm_ok = cur_ok;
    // closed gate
    if (!gate_is_open) begin
      if (en > regs.open_level) begin
        if (!high_t0_ok) begin
          high_t0 = now;
          high_t0_ok = 1'b1;
        end
        if ((now - high_t0) >= regs.open_dwell_ms) begin
          clear_gate_model();
          gate_is_open = 1'b1;
          r.gate_event = EV_OPENED;
          return;
        end
      end else begin
        high_t0_ok = 1'b0;
      end
      r.gate_event = EV_CLOSED_IDLE;
      return;
    end
    // open gate
    close_now = 1'b0;
    if (open_frames < regs.frame_limit) open_frames++;
    if (en < regs.close_level) begin
      if (!low_t0_ok) begin
        low_t0 = now;
        low_t0_ok = 1'b1;
      end
      if ((now - low_t0) >= regs.close_dwell_ms) close_now = 1'b1;
    end else begin
      low_t0_ok = 1'b0;
    end
    if (open_frames >= regs.frame_limit) close_now = 1'b1;
    c = open_frames;
    if (close_now) begin
      clear_gate_model();
      r.gate_event = EV_CYCLE_ENDED;
      r.frame_count = c[9:0];
      return;
    end
    r.gate_event = EV_STILL_OPEN;
    r.frame_count = c[9:0];
  endfunction

  // monitor: config, input and result transactions
  always @(posedge clk) begin
    bit        has;
    out_item_t r, e;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL landmark_motion_gate_core");
      $finish;
    end
    if (rst) begin
      last_norm_ok = 1'b0;
      clear_gate_model();
      regs.open_level = 20'd512;
      regs.close_level = 20'd256;
      regs.open_dwell_ms = 16'd100;
      regs.close_dwell_ms = 16'd200;
      regs.frame_limit = 10'd60;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OPEN_LEVEL:     regs.open_level = cfg_data;
          REG_CLOSE_LEVEL:    regs.close_level = cfg_data;
          REG_OPEN_DWELL_MS:  regs.open_dwell_ms = cfg_data[15:0];
          REG_CLOSE_DWELL_MS: regs.close_dwell_ms = cfg_data[15:0];
          REG_FRAME_LIMIT:    regs.frame_limit = cfg_data[9:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        gate_event_for(in_data, has, r);
        if (has) pending_events = {pending_events, (typed_on ? typed_event : r)};
      end
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          $error("result with nothing expected: gate_event %0d frame_count %0d",
                 out_data.gate_event, out_data.frame_count);
          fail_count++;
        end else begin
          e = pending_events.pop_front();
          if (out_data.gate_event !== e.gate_event) begin
            $error("gate_event expected %0d actual %0d", e.gate_event, out_data.gate_event);
            fail_count++;
          end
          if (out_data.frame_count !== e.frame_count) begin
            $error("frame_count expected %0d actual %0d", e.frame_count,
                   out_data.frame_count);
            fail_count++;
          end
        end
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    out_ready <= !rst && (calm || $urandom_range(99) >= 36);
  end

  // one input transaction, entered and left at a falling edge
  task automatic send_item(in_item_t it);
    if (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_point(int idx, int x, int y, int z, bit [31:0] ts);
    in_item_t it;
    it.absent = 1'b0;
    it.timestamp_ms = ts;
    it.point_index = idx[4:0];
    it.point_x = x[15:0];
    it.point_y = y[15:0];
    it.point_z = z[15:0];
    send_item(it);
  endtask

  task automatic send_absent(bit [31:0] ts);
    in_item_t    it;
    logic [95:0] junk;
    junk = {$urandom(), $urandom(), $urandom()};
    it = junk[$bits(in_item_t)-1:0];
    it.absent = 1'b1;
    it.timestamp_ms = ts;
    send_item(it);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every result is in, then let the frame pipeline drain
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // directed stimulus table
  typedef struct {
    int        kind;
    int        idx;
    int        x, y, z;
    bit [31:0] ts;
    bit        typed;
    out_item_t ev;
  } row_t;

  row_t rows [$];

  function automatic void add_row(int kind, int idx, int x, int y, int z, bit [31:0] ts,
                                  bit typed, logic [1:0] ev, logic [9:0] cnt);
    row_t r;
    r.kind = kind; r.idx = idx; r.x = x; r.y = y; r.z = z; r.ts = ts;
    r.typed = typed; r.ev.gate_event = ev; r.ev.frame_count = cnt;
    rows = {rows, r};
  endfunction

  // coordinates of the current generated hand
  int shape [LM][3];
  bit [31:0] clock_ms;

  task automatic send_shape(int from_idx);
    for (int i = from_idx; i < LM; i++)
      send_point(i, shape[i][0], shape[i][1], shape[i][2],
                 (i == LAST) ? clock_ms : $urandom());
  endtask

  // one random stretch of stimulus; returns counted transactions
  task automatic random_step(output int sent);
    int mode, amp, n, j;
    sent = 0;
    clock_ms += $urandom_range(0, 120);
    if ($urandom_range(99) < 3) clock_ms += $urandom();
    mode = $urandom_range(99);
    if (mode < 25) begin
      // unrelated hand: big motion
      foreach (shape[i, k]) shape[i][k] = $signed(16'($urandom()));
      send_shape(0);
      sent = LM;
    end else if (mode < 52) begin
      // same hand with jitter of varied size
      case ($urandom_range(2))
        0: amp = 2;
        1: amp = 60;
        default: amp = 400;
      endcase
      foreach (shape[i, k])
        shape[i][k] = $signed(16'(shape[i][k] + $urandom_range(0, 2 * amp) - amp));
      send_shape(0);
      sent = LM;
    end else if (mode < 60) begin
      // repeat the stored frame
      send_shape(LAST);
      sent = 1;
    end else if (mode < 67) begin
      // degenerate scale: frame invalid
      for (int k = 0; k < 3; k++) shape[SP][k] = shape[0][k];
      send_shape(0);
      sent = LM;
    end else if (mode < 73) begin
      // tiny scale: normalized values saturate
      for (int k = 0; k < 3; k++) shape[SP][k] = shape[0][k];
      j = $urandom_range(2);
      shape[SP][j] = $signed(16'(shape[0][j] + 1));
      send_shape(0);
      sent = LM;
    end else if (mode < 84) begin
      // partial frame in random order, then the closing landmark
      n = $urandom_range(1, 6);
      for (int m = 0; m < n; m++) begin
        j = $urandom_range(0, LAST - 1);
        for (int k = 0; k < 3; k++)
          shape[j][k] = $signed(16'(shape[j][k] + $urandom_range(0, 1600) - 800));
        send_point(j, shape[j][0], shape[j][1], shape[j][2], $urandom());
      end
      send_shape(LAST);
      sent = n + 1;
    end else if (mode < 93) begin
      send_absent(clock_ms);
      sent = 1;
    end else begin
      // out of range landmark numbers, ignored
      repeat ($urandom_range(1, 3))
        send_point($urandom_range(LM, 31), $urandom(), $urandom(), $urandom(), $urandom());
    end
  endtask

  task automatic write_all(logic [19:0] ol, logic [19:0] cl, logic [15:0] od,
                           logic [15:0] cd, logic [9:0] fl);
    write_reg(REG_OPEN_LEVEL, ol);
    write_reg(REG_CLOSE_LEVEL, cl);
    write_reg(REG_OPEN_DWELL_MS, {4'd0, od});
    write_reg(REG_CLOSE_DWELL_MS, {4'd0, cd});
    write_reg(REG_FRAME_LIMIT, {10'd0, fl});
  endtask

  initial begin
    int got, sent;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    cycle_count = 0;
    calm = 1'b0;
    typed_on = 1'b0;
    clock_ms = $urandom();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset state, extremes, ignored numbers, invalid and saturated frames
    add_row(ROW_ABSENT, 0, 0, 0, 0, 32'd1000, 1, EV_CLOSED_IDLE, 0);
    add_row(ROW_FRAME, 0, 0, 0, 0, 32'd1000, 1, EV_CLOSED_IDLE, 0);
    add_row(ROW_POINT, 31, 32767, -32768, 0, 32'hFFFFFFFF, 0, 0, 0);
    add_row(ROW_POINT, 21, -1, 1, -1, 32'd0, 0, 0, 0);
    add_row(ROW_POINT, LAST, 0, 0, 0, 32'd1000, 1, EV_CLOSED_IDLE, 0);
    add_row(ROW_POINT, SP, -32768, -32768, -32768, 32'd1000, 0, 0, 0);
    add_row(ROW_POINT, LAST, 0, 0, 0, 32'd1000, 1, EV_CLOSED_IDLE, 0);
    add_row(ROW_POINT, SP, -32767, -32768, -32768, 32'd1000, 0, 0, 0);
    add_row(ROW_POINT, LAST, 0, 0, 0, 32'd1000, 1, EV_CLOSED_IDLE, 0);
    add_row(ROW_POINT, SP, 32767, 32767, 32767, 32'd1000, 0, 0, 0);
    add_row(ROW_POINT, LAST, 0, 0, 0, 32'd1000, 0, 0, 0);
    add_row(ROW_POINT, 5, 32767, -32768, 32767, 32'd1000, 0, 0, 0);
    add_row(ROW_POINT, LAST, -32768, 32767, -32768, 32'd1000, 0, 0, 0);
    add_row(ROW_POINT, 5, -32768, 32767, -32768, 32'd1000, 0, 0, 0);
    add_row(ROW_POINT, LAST, 32767, -32768, 32767, 32'd1100, 0, 0, 0);
    add_row(ROW_POINT, LAST, 32767, -32768, 32767, 32'd1200, 0, 0, 0);
    add_row(ROW_ABSENT, 0, 0, 0, 0, 32'd1300, 0, 0, 0);
    add_row(ROW_ABSENT, 0, 0, 0, 0, 32'd1400, 1, EV_CLOSED_IDLE, 0);

    foreach (rows[r]) begin
      typed_on = rows[r].typed;
      typed_event = rows[r].ev;
      case (rows[r].kind)
        ROW_ABSENT: send_absent(rows[r].ts);
        ROW_FRAME: begin
          // wrist at one corner, scale point at the other
          for (int i = 0; i < LM; i++) begin
            shape[i][0] = $signed(16'(i * 3100 - 32768));
            shape[i][1] = $signed(16'(32767 - i * 2900));
            shape[i][2] = $signed(16'(i * 1700));
          end
          shape[SP][0] = 32767;
          shape[SP][1] = -32768;
          shape[SP][2] = 32767;
          clock_ms = rows[r].ts;
          send_shape(0);
        end
        default: begin
          send_point(rows[r].idx, rows[r].x, rows[r].y, rows[r].z, rows[r].ts);
          if (rows[r].idx < LM) shape[rows[r].idx] = '{rows[r].x, rows[r].y, rows[r].z};
        end
      endcase
    end
    typed_on = 1'b0;
    clock_ms = $urandom();

    // random phases, each under its own register setting
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: write_all(20'd0, 20'd0, 16'd0, 16'd0, 10'd1);
        1: write_all(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 10'd1023);
        2: write_all(20'd300, 20'd200, 16'd50, 16'd100, 10'd8);
        3: write_all(20'd100, 20'd50, 16'd0, 16'd0, 10'd0);
        4: write_all(20'($urandom_range(0, 4000)), 20'($urandom_range(0, 2000)),
                     16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                     10'($urandom_range(1, 40)));
        default: write_all(20'd512, 20'd256, 16'd100, 16'd200, 10'd60);
      endcase
      calm = (p == 2);
      got = 0;
      while (got < PHASE_ITEMS) begin
        random_step(sent);
        got += sent;
      end
      calm = 1'b0;
    end

    drain();
    if (fail_count == 0) begin
      $display("PASS landmark_motion_gate_core");
    end else begin
      $display("FAIL landmark_motion_gate_core");
    end
    $finish;
  end

endmodule
